// ===== src/sics_pkg.sv =====
// Shared constants and types for the sparse index champion selector.
package sics_pkg;

  localparam int TableKeys   = 512;
  localparam int NamesPerKey = 16;
  localparam int MaxHooks    = 16;
  localparam int KeyBits     = 64;
  localparam int NameBits    = 16;
  localparam int CandMax     = MaxHooks * NamesPerKey;
  localparam int ScoreBits   = 10;

  localparam int KeyAw  = $clog2(TableKeys);
  localparam int NameAw = $clog2(TableKeys * NamesPerKey);
  localparam int CandAw = $clog2(CandMax);
  localparam int HookAw = $clog2(MaxHooks);
  localparam int JAw    = $clog2(NamesPerKey);

  localparam int LimitBits = 10;
  localparam int SizeBits  = 5;

  typedef logic [KeyBits-1:0]  key_t;
  typedef logic [NameBits-1:0] name_t;
  typedef logic [ScoreBits-1:0] score_t;

  // One candidate entry: manifest id and its score in half points.
  typedef struct packed {
    name_t  id;
    score_t score;
  } cand_t;

  localparam logic [1:0] StAdded    = 2'd0;
  localparam logic [1:0] StListFull = 2'd1;
  localparam logic [1:0] StTblFull  = 2'd2;
  localparam logic [1:0] StQuery    = 2'd3;

  localparam logic [1:0] CfgLimit = 2'd0;
  localparam logic [1:0] CfgSize  = 2'd1;

  localparam logic KindAdd   = 1'b0;
  localparam logic KindQuery = 1'b1;

endpackage

// ===== src/sics_ram.sv =====
// Generic single-port-write, single-port-read memory with registered read data.
module sics_ram #(
  parameter int DEPTH = 512,
  parameter int WIDTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/sparse_index_champion_select.sv =====
// Top level of the sparse index with champion selection.
//
// The block keeps a sparse deduplication index in four on-chip memories: hook
// keys (512 x 64), per-key name counts (512 x 5), manifest id lists
// (8192 x 16, sixteen slots per key) and a candidate table of id and score
// (256 entries). One input transaction is taken at a time; in_tready is high
// only while the sequencer is idle. An add transaction searches the key memory
// linearly, reading and then comparing each stored key, then writes if there is
// room and returns one status transaction. A query hook that is not last is
// buffered and returns nothing. The last hook starts two passes over the
// buffered hooks: each hook costs a key search, and each listed id a linear
// search of the candidate table, so the evaluation time grows with keys times
// hooks plus names times candidates. Champions then leave one per cycle
// through the output register, which also lets the result wait for out_tready.
// No memory needs clearing after reset; entries are read only after written.
module sparse_index_champion_select (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // key[63:0], manifest_id[79:64]
  input  logic        in_tuser,   // kind
  input  logic        in_tlast,   // last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // champion[15:0]
  output logic [2:0]  out_tuser,  // status[1:0], has_champion[2]
  output logic        out_tlast,  // last_res
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_wdata
);
  import sics_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_KRD   = 4'd1;
  localparam logic [3:0] S_KCMP  = 4'd2;
  localparam logic [3:0] S_NCGET = 4'd3;
  localparam logic [3:0] S_NRD   = 4'd4;
  localparam logic [3:0] S_NGET  = 4'd5;
  localparam logic [3:0] S_CRD   = 4'd6;
  localparam logic [3:0] S_CCMP  = 4'd7;
  localparam logic [3:0] S_HOOK  = 4'd8;
  localparam logic [3:0] S_PICK  = 4'd9;
  localparam logic [3:0] S_EMIT  = 4'd10;
  localparam logic [3:0] S_ARES  = 4'd11;

  localparam logic [1:0] M_ADD   = 2'd0;
  localparam logic [1:0] M_PASS1 = 2'd1;
  localparam logic [1:0] M_PASS2 = 2'd2;

  // Configuration.
  logic [LimitBits-1:0] limit_r;
  logic [SizeBits-1:0]  size_r;

  // Sequencer state.
  logic [3:0]          state_r;
  logic [1:0]          mode_r;
  key_t                skey_r;
  name_t               id_r;
  logic [KeyAw:0]      key_cnt_r;
  logic [KeyAw:0]      ki_r;
  logic [SizeBits-1:0] n_r;
  logic [JAw:0]        j_r;
  name_t               nid_r;
  logic [CandAw:0]     cand_cnt_r;
  logic [CandAw:0]     ci_r;
  logic [HookAw:0]     hook_cnt_r;
  logic [HookAw:0]     h_r;
  key_t                hook_buf_r [MaxHooks];
  name_t               champ_r [MaxHooks];
  logic [HookAw:0]     champ_cnt_r;
  logic [HookAw:0]     e_r;
  logic [CandAw-1:0]   best_idx_r;
  name_t               best_id_r;
  score_t              best_score_r;
  logic [1:0]          astat_r;

  // Output register.
  logic        out_valid_r;
  logic [15:0] out_champ_r;
  logic [1:0]  out_status_r;
  logic        out_has_r;
  logic        out_last_r;

  // Memory ports.
  logic              k_we;
  logic [KeyAw-1:0]  k_waddr, k_raddr;
  key_t              k_wdata, k_rdata;
  logic              c_we;
  logic [KeyAw-1:0]  c_waddr, c_raddr;
  logic [SizeBits-1:0] c_wdata, c_rdata;
  logic              n_we;
  logic [NameAw-1:0] n_waddr, n_raddr;
  name_t             n_wdata, n_rdata;
  logic              d_we;
  logic [CandAw-1:0] d_waddr, d_raddr;
  cand_t             d_wdata, d_rdata;

  sics_ram #(.DEPTH(TableKeys), .WIDTH(KeyBits)) u_key_ram (
    .clk(clk), .we(k_we), .waddr(k_waddr), .wdata(k_wdata), .raddr(k_raddr), .rdata(k_rdata)
  );
  sics_ram #(.DEPTH(TableKeys), .WIDTH(SizeBits)) u_cnt_ram (
    .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata), .raddr(c_raddr), .rdata(c_rdata)
  );
  sics_ram #(.DEPTH(TableKeys * NamesPerKey), .WIDTH(NameBits)) u_name_ram (
    .clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata), .raddr(n_raddr), .rdata(n_rdata)
  );
  sics_ram #(.DEPTH(CandMax), .WIDTH($bits(cand_t))) u_cand_ram (
    .clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata), .raddr(d_raddr), .rdata(d_rdata)
  );

  // Effective limits after clamping to the table geometry.
  logic [KeyAw:0]      lim_keys;
  logic [SizeBits-1:0] lim_names;
  logic                slot_free;
  logic                key_hit;
  logic                cand_hit;
  logic                seen;
  logic                in_acc;

  always_comb begin
    lim_keys  = (limit_r > LimitBits'(TableKeys)) ? (KeyAw+1)'(TableKeys)
                                                  : (KeyAw+1)'(limit_r);
    lim_names = (size_r > SizeBits'(NamesPerKey)) ? SizeBits'(NamesPerKey) : size_r;
    slot_free = !out_valid_r || out_tready;
    key_hit   = (k_rdata == skey_r);
    cand_hit  = (d_rdata.id == nid_r);
    in_acc    = in_tvalid && in_tready;
    seen      = 1'b0;
    for (int c = 0; c < MaxHooks; c++) begin
      if ((HookAw+1)'(c) < champ_cnt_r && champ_r[c] == best_id_r) begin
        seen = 1'b1;
      end
    end
  end

  assign in_tready = (state_r == S_IDLE);

  // Read addresses follow the probe counters; data returns the next cycle.
  assign k_raddr = ki_r[KeyAw-1:0];
  assign c_raddr = ki_r[KeyAw-1:0];
  assign n_raddr = {ki_r[KeyAw-1:0], j_r[JAw-1:0]};
  assign d_raddr = ci_r[CandAw-1:0];

  // Memory writes.
  always_comb begin
    k_we = 1'b0; k_waddr = key_cnt_r[KeyAw-1:0]; k_wdata = skey_r;
    c_we = 1'b0; c_waddr = key_cnt_r[KeyAw-1:0]; c_wdata = SizeBits'(1);
    n_we = 1'b0; n_waddr = {key_cnt_r[KeyAw-1:0], JAw'(0)}; n_wdata = id_r;
    d_we = 1'b0; d_waddr = cand_cnt_r[CandAw-1:0];
    d_wdata = '{id: nid_r, score: ScoreBits'(2)};
    unique case (state_r)
      S_KRD: begin
        if (ki_r >= key_cnt_r && mode_r == M_ADD && key_cnt_r < lim_keys) begin
          k_we = 1'b1;
          c_we = 1'b1;
          n_we = 1'b1;
        end
      end
      S_NCGET: begin
        if (mode_r == M_ADD && c_rdata < lim_names &&
            c_rdata < SizeBits'(NamesPerKey)) begin
          c_we    = 1'b1;
          c_waddr = ki_r[KeyAw-1:0];
          c_wdata = c_rdata + SizeBits'(1);
          n_we    = 1'b1;
          n_waddr = {ki_r[KeyAw-1:0], c_rdata[JAw-1:0]};
        end
      end
      S_CRD: begin
        if (ci_r >= cand_cnt_r && mode_r == M_PASS1 &&
            cand_cnt_r < (CandAw+1)'(CandMax)) begin
          d_we = 1'b1;
        end
      end
      S_CCMP: begin
        if (cand_hit && mode_r == M_PASS1) begin
          d_we    = 1'b1;
          d_waddr = ci_r[CandAw-1:0];
          d_wdata = '{id: d_rdata.id, score: d_rdata.score + ScoreBits'(2)};
        end
      end
      S_PICK: begin
        if (best_score_r != '0 && !seen && champ_cnt_r < (HookAw+1)'(MaxHooks)) begin
          d_we    = 1'b1;
          d_waddr = best_idx_r;
          d_wdata = '{id: best_id_r, score: best_score_r + ScoreBits'(1)};
        end
      end
      default: ;
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LimitBits'(500);
      size_r  <= SizeBits'(10);
    end else if (cfg_we) begin
      if (cfg_index == CfgLimit) limit_r <= cfg_wdata;
      if (cfg_index == CfgSize)  size_r  <= cfg_wdata[SizeBits-1:0];
    end
  end

  // Payload registers without reset.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      skey_r <= in_tdata[KeyBits-1:0];
      id_r   <= in_tdata[79:64];
      if (in_tuser == KindQuery && hook_cnt_r < (HookAw+1)'(MaxHooks)) begin
        hook_buf_r[hook_cnt_r[HookAw-1:0]] <= in_tdata[KeyBits-1:0];
      end
    end else if (state_r == S_HOOK && h_r < hook_cnt_r) begin
      skey_r <= hook_buf_r[h_r[HookAw-1:0]];
    end
    if (state_r == S_NCGET) n_r <= c_rdata;
    if (state_r == S_NGET)  nid_r <= n_rdata;
    if (state_r == S_PICK && d_we) begin
      champ_r[champ_cnt_r[HookAw-1:0]] <= best_id_r;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      mode_r       <= M_ADD;
      key_cnt_r    <= '0;
      hook_cnt_r   <= '0;
      cand_cnt_r   <= '0;
      champ_cnt_r  <= '0;
      ki_r         <= '0;
      j_r          <= '0;
      ci_r         <= '0;
      h_r          <= '0;
      e_r          <= '0;
      best_idx_r   <= '0;
      best_id_r    <= '0;
      best_score_r <= '0;
      astat_r      <= StAdded;
      out_valid_r  <= 1'b0;
      out_champ_r  <= '0;
      out_status_r <= StAdded;
      out_has_r    <= 1'b0;
      out_last_r   <= 1'b0;
    end else begin
      // The result states reload the output register themselves when it frees.
      if (out_valid_r && out_tready && state_r != S_EMIT && state_r != S_ARES) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            ki_r <= '0;
            if (in_tuser == KindAdd) begin
              mode_r  <= M_ADD;
              state_r <= S_KRD;
            end else begin
              if (hook_cnt_r < (HookAw+1)'(MaxHooks)) hook_cnt_r <= hook_cnt_r + 1'b1;
              if (in_tlast) begin
                mode_r      <= M_PASS1;
                h_r         <= '0;
                cand_cnt_r  <= '0;
                champ_cnt_r <= '0;
                state_r     <= S_HOOK;
              end
            end
          end
        end
        S_HOOK: begin
          if (h_r < hook_cnt_r) begin
            ki_r         <= '0;
            best_score_r <= '0;
            state_r      <= S_KRD;
          end else if (mode_r == M_PASS1) begin
            mode_r <= M_PASS2;
            h_r    <= '0;
          end else begin
            hook_cnt_r <= '0;
            e_r        <= '0;
            state_r    <= S_EMIT;
          end
        end
        S_KRD: begin
          if (ki_r < key_cnt_r) begin
            state_r <= S_KCMP;
          end else if (mode_r == M_ADD) begin
            if (key_cnt_r < lim_keys) begin
              key_cnt_r <= key_cnt_r + 1'b1;
              astat_r   <= StAdded;
            end else begin
              astat_r <= StTblFull;
            end
            state_r <= S_ARES;
          end else begin
            h_r     <= h_r + 1'b1;
            state_r <= S_HOOK;
          end
        end
        S_KCMP: begin
          if (key_hit) begin
            state_r <= S_NCGET;
          end else begin
            ki_r    <= ki_r + 1'b1;
            state_r <= S_KRD;
          end
        end
        S_NCGET: begin
          if (mode_r == M_ADD) begin
            astat_r <= c_we ? StAdded : StListFull;
            state_r <= S_ARES;
          end else begin
            j_r     <= '0;
            state_r <= S_NRD;
          end
        end
        S_NRD: begin
          if (j_r < (JAw+1)'(n_r) && j_r < (JAw+1)'(NamesPerKey)) begin
            state_r <= S_NGET;
          end else if (mode_r == M_PASS1) begin
            h_r     <= h_r + 1'b1;
            state_r <= S_HOOK;
          end else begin
            state_r <= S_PICK;
          end
        end
        S_NGET: begin
          ci_r    <= '0;
          state_r <= S_CRD;
        end
        S_CRD: begin
          if (ci_r < cand_cnt_r) begin
            state_r <= S_CCMP;
          end else begin
            if (d_we) cand_cnt_r <= cand_cnt_r + 1'b1;
            j_r     <= j_r + 1'b1;
            state_r <= S_NRD;
          end
        end
        S_CCMP: begin
          if (cand_hit) begin
            if (mode_r == M_PASS2 && d_rdata.score > best_score_r) begin
              best_score_r <= d_rdata.score;
              best_id_r    <= d_rdata.id;
              best_idx_r   <= ci_r[CandAw-1:0];
            end
            j_r     <= j_r + 1'b1;
            state_r <= S_NRD;
          end else begin
            ci_r    <= ci_r + 1'b1;
            state_r <= S_CRD;
          end
        end
        S_PICK: begin
          if (d_we) champ_cnt_r <= champ_cnt_r + 1'b1;
          h_r     <= h_r + 1'b1;
          state_r <= S_HOOK;
        end
        S_EMIT: begin
          if (slot_free) begin
            out_valid_r  <= 1'b1;
            out_status_r <= StQuery;
            if (champ_cnt_r == '0) begin
              out_champ_r <= '0;
              out_has_r   <= 1'b0;
              out_last_r  <= 1'b1;
              state_r     <= S_IDLE;
            end else begin
              out_champ_r <= champ_r[e_r[HookAw-1:0]];
              out_has_r   <= 1'b1;
              out_last_r  <= (e_r + 1'b1 == champ_cnt_r);
              e_r         <= e_r + 1'b1;
              if (e_r + 1'b1 == champ_cnt_r) state_r <= S_IDLE;
            end
          end
        end
        S_ARES: begin
          if (slot_free) begin
            out_valid_r  <= 1'b1;
            out_status_r <= astat_r;
            out_champ_r  <= '0;
            out_has_r    <= 1'b0;
            out_last_r   <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_champ_r;
  assign out_tuser  = {out_has_r, out_status_r};
  assign out_tlast  = out_last_r;

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the sparse index champion selector.
//
// Stimulus is driven at the falling clock edge and the outputs are sampled
// at the rising edge. A behavioral predictor keeps its own copy of the key
// table, the per-key manifest lists and the open hook buffer. Every accepted
// input transaction is applied to it, and the statuses or champions it
// predicts are queued. A checker process compares each accepted output
// transaction, field by field, with the oldest queued prediction.
module testbench;
  import sics_pkg::*;

  localparam int Period    = 12;
  localparam int CycleCap  = 20000000;
  localparam int PoolSize  = 20;

  // One predicted output transaction.
  typedef struct {
    logic [1:0]  status;
    logic [15:0] champion;
    logic        has_champion;
    logic        last_res;
  } index_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [79:0] in_tdata;   // key[63:0], manifest_id[79:64]
  logic        in_tuser;   // kind
  logic        in_tlast;   // last
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // champion[15:0]
  logic [2:0]  out_tuser;  // status[1:0], has_champion[2]
  logic        out_tlast;  // last_res
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [9:0]  cfg_wdata;

  sparse_index_champion_select u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // Shadow copy of the index held by the block.
  logic [9:0]  shadow_limit;
  logic [4:0]  shadow_size;
  logic [63:0] shadow_keys [TableKeys];
  int          shadow_nlen [TableKeys];
  logic [15:0] shadow_names [TableKeys][NamesPerKey];
  int          shadow_key_count;
  logic [63:0] open_hooks [MaxHooks];
  int          open_hook_count;

  index_result_t pending_results[$];
  index_result_t head_result;

  int          fail_count;
  int          cycle_count;
  int          tx_idle_pct;
  int          rx_idle_pct;
  logic [63:0] key_pool [PoolSize];

  initial begin
    clk = 1'b0;
    forever #(Period / 2) clk = ~clk;
  end

  // Hard stop in case the block hangs somewhere.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleCap) begin
      $display("sparse_index_champion_select test failed");
      $finish;
    end
  end

  // The receiver stalls at random, at the rate set for the current phase.
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  function automatic void push_result(logic [1:0] st, logic [15:0] ch, logic has,
                                      logic lst);
    index_result_t r;
    r.status = st;
    r.champion = ch;
    r.has_champion = has;
    r.last_res = lst;
    pending_results.insert(pending_results.size(), r);
  endfunction

  function automatic int lookup_key(logic [63:0] k);
    for (int i = 0; i < shadow_key_count; i++)
      if (shadow_keys[i] == k) return i;
    return -1;
  endfunction

  // Store a manifest id under a key, or refuse it, and predict the status.
  function automatic void predict_add(logic [63:0] k, logic [15:0] id);
    int slot;
    int name_cap;
    int key_cap;
    slot = lookup_key(k);
    name_cap = (shadow_size < NamesPerKey) ? shadow_size : NamesPerKey;
    key_cap = (shadow_limit < TableKeys) ? shadow_limit : TableKeys;
    if (slot >= 0) begin
      if (shadow_nlen[slot] >= name_cap) begin
        push_result(StListFull, 16'h0, 1'b0, 1'b1);
        return;
      end
      shadow_names[slot][shadow_nlen[slot]] = id;
      shadow_nlen[slot]++;
    end else begin
      if (shadow_key_count >= key_cap) begin
        push_result(StTblFull, 16'h0, 1'b0, 1'b1);
        return;
      end
      shadow_keys[shadow_key_count] = k;
      shadow_names[shadow_key_count][0] = id;
      shadow_nlen[shadow_key_count] = 1;
      shadow_key_count++;
    end
    push_result(StAdded, 16'h0, 1'b0, 1'b1);
  endfunction

  // Score every listed id of the found hooks, then pick the champions.
  function automatic void predict_champions();
    logic [15:0] cand_id [CandMax];
    int          cand_score [CandMax];
    int          cand_count;
    logic [15:0] champs [MaxHooks];
    int          champ_count;
    int          slot;
    int          ci;
    int          best;
    int          best_score;
    logic        seen;
    cand_count = 0;
    champ_count = 0;
    for (int h = 0; h < open_hook_count; h++) begin
      slot = lookup_key(open_hooks[h]);
      if (slot < 0) continue;
      for (int j = 0; j < shadow_nlen[slot]; j++) begin
        ci = -1;
        for (int c = 0; c < cand_count; c++)
          if (ci < 0 && cand_id[c] == shadow_names[slot][j]) ci = c;
        if (ci >= 0) begin
          cand_score[ci] += 2;
        end else if (cand_count < CandMax) begin
          cand_id[cand_count] = shadow_names[slot][j];
          cand_score[cand_count] = 2;
          cand_count++;
        end
      end
    end
    for (int h = 0; h < open_hook_count; h++) begin
      slot = lookup_key(open_hooks[h]);
      if (slot < 0) continue;
      best = -1;
      best_score = 0;
      for (int j = 0; j < shadow_nlen[slot]; j++) begin
        ci = -1;
        for (int c = 0; c < cand_count; c++)
          if (ci < 0 && cand_id[c] == shadow_names[slot][j]) ci = c;
        // Strictly greater, so the first listed id keeps a tie.
        if (ci >= 0 && cand_score[ci] > best_score) begin
          best = ci;
          best_score = cand_score[ci];
        end
      end
      if (best < 0) continue;
      seen = 1'b0;
      for (int c = 0; c < champ_count; c++)
        if (champs[c] == cand_id[best]) seen = 1'b1;
      if (!seen && champ_count < MaxHooks) begin
        champs[champ_count] = cand_id[best];
        champ_count++;
        cand_score[best] += 1;
      end
    end
    open_hook_count = 0;
    if (champ_count == 0) begin
      push_result(StQuery, 16'h0, 1'b0, 1'b1);
    end else begin
      for (int c = 0; c < champ_count; c++)
        push_result(StQuery, champs[c], 1'b1, c == champ_count - 1);
    end
  endfunction

  function automatic void predict_item(logic kind, logic [63:0] k, logic [15:0] id,
                                       logic lst);
    if (kind == KindAdd) begin
      predict_add(k, id);
    end else begin
      // Hooks past the buffer depth are dropped, but a last one still counts.
      if (open_hook_count < MaxHooks) begin
        open_hooks[open_hook_count] = k;
        open_hook_count++;
      end
      if (lst) predict_champions();
    end
  endfunction

  // Compare each accepted output transaction with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: champion %0h status %0d", out_tdata, out_tuser[1:0]);
        fail_count++;
      end else begin
        head_result = pending_results.pop_front();
        if (out_tuser[1:0] !== head_result.status) begin
          $error("status: expected %0d, got %0d", head_result.status, out_tuser[1:0]);
          fail_count++;
        end
        if (out_tdata !== head_result.champion) begin
          $error("champion: expected %0h, got %0h", head_result.champion, out_tdata);
          fail_count++;
        end
        if (out_tuser[2] !== head_result.has_champion) begin
          $error("has_champion: expected %0d, got %0d", head_result.has_champion,
                 out_tuser[2]);
          fail_count++;
        end
        if (out_tlast !== head_result.last_res) begin
          $error("last_res: expected %0d, got %0d", head_result.last_res, out_tlast);
          fail_count++;
        end
      end
    end
  end

  // Offer one transaction, with a random gap in front, and wait until taken.
  task automatic send_item(logic kind, logic [63:0] k, logic [15:0] id, logic lst);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {id, k};
    in_tlast  <= lst;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_item(kind, k, id, lst);
  endtask

  task automatic add_id(logic [63:0] k, logic [15:0] id);
    send_item(KindAdd, k, id, 1'b0);
  endtask

  task automatic hook(logic [63:0] k, logic lst);
    send_item(KindQuery, k, 16'($urandom), lst);
  endtask

  // Stop sending and let every predicted result drain; the sequencer must
  // also be back to idle, since a hook that is not last returns nothing.
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0 || !in_tready) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [9:0] value);
    drain();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (idx == CfgLimit) shadow_limit = value;
    else if (idx == CfgSize) shadow_size = value[4:0];
  endtask

  task automatic test_defaults();
    // Query on an empty table, then both key and id extremes.
    hook(64'h0, 1'b1);
    add_id(64'h0, 16'h0000);
    add_id(64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF);
    hook(64'h0, 1'b0);
    hook(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    hook(64'h1234_5678_9ABC_DEF0, 1'b1);
  endtask

  task automatic test_list_limits();
    write_reg(CfgSize, 10'd1);
    add_id(64'hFFFF_FFFF_FFFF_FFFF, 16'h0055);
    // A zero list size still creates the key, then refuses it.
    write_reg(CfgSize, 10'd0);
    add_id(64'hA5A5_0000_0000_0001, 16'h0003);
    add_id(64'hA5A5_0000_0000_0001, 16'h0004);
    // An oversized list size is clamped to the per-key capacity.
    write_reg(CfgSize, 10'd31);
  endtask

  task automatic test_table_limits();
    write_reg(CfgLimit, 10'd0);
    add_id(64'h5A5A_0000_0000_0002, 16'h0001);
    write_reg(CfgLimit, 10'd4);
    add_id(64'h5A5A_0000_0000_0002, 16'h0001);
    write_reg(CfgLimit, 10'd512);
  endtask

  task automatic test_scoring();
    logic [63:0] ka;
    logic [63:0] kb;
    ka = 64'h0000_0000_0000_0A0A;
    kb = 64'h0000_0000_0000_0B0B;
    // Duplicate ids under one key, a tie between keys, and duplicate hooks.
    add_id(ka, 16'd5);
    add_id(ka, 16'd5);
    add_id(ka, 16'd7);
    add_id(kb, 16'd7);
    add_id(kb, 16'd9);
    hook(ka, 1'b0);
    hook(kb, 1'b0);
    hook(kb, 1'b1);
    // A hook whose key is added while the query is still open.
    hook(64'h0000_0000_0000_0C0C, 1'b0);
    add_id(64'h0000_0000_0000_0C0C, 16'd9);
    hook(64'h0000_0000_0000_0C0C, 1'b1);
  endtask

  task automatic test_hook_overflow();
    // Eighteen hooks: the two past the buffer depth are dropped.
    for (int i = 0; i < 18; i++)
      hook((i % 2 == 0) ? 64'h0000_0000_0000_0A0A : 64'h0000_0000_0000_0B0B, i == 17);
  endtask

  task automatic random_phase(int items, int tx_pct, int rx_pct);
    int sel;
    int len;
    logic [63:0] k;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int n = 0; n < items; n++) begin
      sel = $urandom_range(99);
      if (sel < 35) begin
        add_id(key_pool[$urandom_range(PoolSize - 1)],
               ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(11)));
      end else if (sel < 45) begin
        add_id({$urandom, $urandom}, 16'($urandom));
      end else if (sel < 95) begin
        // A well-formed query, mostly short, now and then past the buffer depth.
        len = ($urandom_range(7) == 0) ? $urandom_range(14, 19) : $urandom_range(1, 5);
        for (int h = 0; h < len; h++) begin
          k = ($urandom_range(9) == 0) ? {$urandom, $urandom}
                                       : key_pool[$urandom_range(PoolSize - 1)];
          hook(k, h == len - 1);
        end
      end else begin
        // A stray hook, left open until the next query closes it.
        hook(key_pool[$urandom_range(PoolSize - 1)], 1'b0);
      end
    end
    // Close any query left open so the phase ends with nothing buffered.
    hook({$urandom, $urandom}, 1'b1);
  endtask

  task automatic test_random();
    write_reg(CfgLimit, 10'd512);
    write_reg(CfgSize, 10'd16);
    random_phase(20, 12, 62);
    write_reg(CfgLimit, 10'd60);
    write_reg(CfgSize, 10'd4);
    random_phase(20, 62, 12);
    // Unknown register indexes must leave both settings alone.
    write_reg(2'd2, 10'd1);
    write_reg(2'd3, 10'd0);
    write_reg(CfgSize, 10'd31);
    random_phase(20, 0, 0);
  endtask

  task automatic test_table_full();
    // An oversized limit is clamped to the table depth, so new keys still go in.
    write_reg(CfgLimit, 10'd1023);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (3) add_id({$urandom, $urandom}, 16'($urandom));
    // Then a limit just above the current count fills up and overflows.
    write_reg(CfgLimit, 10'(shadow_key_count + 2));
    repeat (3) add_id({$urandom, $urandom}, 16'($urandom));
    hook(key_pool[0], 1'b0);
    hook(shadow_keys[shadow_key_count - 1], 1'b1);
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    in_tlast = 1'b0;
    out_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    fail_count = 0;
    cycle_count = 0;
    tx_idle_pct = 12;
    rx_idle_pct = 62;
    shadow_limit = 10'd500;
    shadow_size = 5'd10;
    shadow_key_count = 0;
    open_hook_count = 0;
    for (int i = 0; i < PoolSize; i++) key_pool[i] = {$urandom, $urandom};
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    test_defaults();
    test_list_limits();
    test_table_limits();
    test_scoring();
    test_hook_overflow();
    test_random();
    test_table_full();

    drain();
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("sparse_index_champion_select test passed");
    end else begin
      $display("sparse_index_champion_select test failed");
    end
    $finish;
  end

endmodule
